### design/iirdf_pkg.sv
// Shared types, constants and coefficient tables for the order-6 DF2T IIR filter.
package iirdf_pkg;

    localparam int TAPS_DEF  = 7;
    localparam int TAPS_MAX  = 16;
    localparam int PHASE_W   = $clog2(TAPS_MAX);
    localparam int SAMPLE_W  = 64;
    localparam int ACC_W     = 96;
    localparam int COEF_W    = 32;
    localparam int CHUNK_W   = 32;
    localparam int OPND_W    = CHUNK_W + 1;
    localparam int PROD_W    = COEF_W + OPND_W;
    localparam int SHIFT_OUT = 25;
    localparam int KEEP_W    = 8;

    typedef enum logic [2:0] {
        SEL_X0 = 3'd0,
        SEL_X1 = 3'd1,
        SEL_Y0 = 3'd2,
        SEL_Y1 = 3'd3,
        SEL_Y2 = 3'd4
    } opnd_sel_t;

    typedef struct packed {
        logic                 valid;
        logic                 first;
        logic                 last;
        opnd_sel_t            sel;
        logic [PHASE_W-1:0]   phase;
    } mac_op_t;

    function automatic logic signed [COEF_W-1:0] coef_b(input logic [PHASE_W-1:0] idx);
        logic signed [COEF_W-1:0] c;
        case (idx)
            4'd0:    c = 32'sd17;
            4'd1:    c = 32'sd100;
            4'd2:    c = 32'sd249;
            4'd3:    c = 32'sd332;
            4'd4:    c = 32'sd249;
            4'd5:    c = 32'sd100;
            4'd6:    c = 32'sd17;
            default: c = '0;
        endcase
        return c;
    endfunction

    function automatic logic signed [COEF_W-1:0] coef_a(input logic [PHASE_W-1:0] idx);
        logic signed [COEF_W-1:0] c;
        case (idx)
            4'd0:    c = 32'sd33554432;
            4'd1:    c = -32'sd176896233;
            4'd2:    c = 32'sd389900074;
            4'd3:    c = -32'sd459786179;
            4'd4:    c = 32'sd305884427;
            4'd5:    c = -32'sd108831111;
            4'd6:    c = 32'sd16175653;
            default: c = '0;
        endcase
        return c;
    endfunction

endpackage

### design/iirdf_seq.sv
// Sequencer that issues one multiply-accumulate operation per cycle for each sample.
module iirdf_seq
    import iirdf_pkg::*;
#(
    parameter int TAPS = TAPS_DEF
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  logic    slot_free,
    output mac_op_t op,
    output logic    busy,
    output logic    load_out
);

    localparam logic [PHASE_W-1:0] LAST_PHASE = PHASE_W'(TAPS - 1);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_RUN   = 4'b0010,
        ST_FLUSH = 4'b0100,
        ST_HOLD  = 4'b1000
    } state_t;

    state_t             state_reg, state_next;
    logic [PHASE_W-1:0] phase_reg, phase_next;
    opnd_sel_t          sel_reg, sel_next;
    logic               end_of_phase;

    assign end_of_phase = (phase_reg == '0) ? (sel_reg == SEL_X1) : (sel_reg == SEL_Y2);

    always_comb
    begin
        op.valid = (state_reg == ST_RUN);
        op.first = (sel_reg == SEL_X0);
        op.last  = end_of_phase;
        op.sel   = sel_reg;
        op.phase = phase_reg;
    end

    assign busy = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        sel_next   = sel_reg;
        load_out   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_RUN;
                    phase_next = '0;
                    sel_next   = SEL_X0;
                end
            end
            ST_RUN:
            begin
                if (end_of_phase)
                begin
                    sel_next = SEL_X0;
                    if (phase_reg == LAST_PHASE)
                        state_next = ST_FLUSH;
                    else
                        phase_next = phase_reg + 1'b1;
                end
                else
                begin
                    unique case (sel_reg)
                        SEL_X0:  sel_next = SEL_X1;
                        SEL_X1:  sel_next = SEL_Y0;
                        SEL_Y0:  sel_next = SEL_Y1;
                        SEL_Y1:  sel_next = SEL_Y2;
                        default: sel_next = SEL_X0;
                    endcase
                end
            end
            ST_FLUSH, ST_HOLD:
            begin
                if (slot_free)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_HOLD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            phase_reg <= '0;
            sel_reg   <= SEL_X0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            sel_reg   <= sel_next;
        end
    end

endmodule

### design/iirdf_mac.sv
// Shared multiplier, 96-bit accumulator, output register and delay line.
module iirdf_mac
    import iirdf_pkg::*;
#(
    parameter int TAPS = TAPS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  mac_op_t             op,
    input  logic [SAMPLE_W-1:0] x,
    output logic [ACC_W-1:0]    y
);

    localparam int NDELAY = TAPS - 1;
    localparam int DIDX_W = (NDELAY > 1) ? $clog2(NDELAY) : 1;
    localparam logic [PHASE_W-1:0] NDLY = PHASE_W'(NDELAY);

    logic signed [COEF_W-1:0] coef_sel;
    logic signed [OPND_W-1:0] opnd_sel;
    logic signed [PROD_W-1:0] prod_reg;
    mac_op_t                  op_reg;
    logic [ACC_W-1:0]         acc_reg, acc_next;
    logic [ACC_W-1:0]         y_reg;
    logic [ACC_W-1:0]         dly_reg [NDELAY];
    logic [ACC_W-1:0]         term_ext, term, init, base;
    logic                     neg;
    logic [PHASE_W-1:0]       rd_full, wr_full;

    always_comb
    begin
        unique case (op.sel)
            SEL_X0:  opnd_sel = {1'b0, x[CHUNK_W-1:0]};
            SEL_X1:  opnd_sel = {x[SAMPLE_W-1], x[SAMPLE_W-1:CHUNK_W]};
            SEL_Y0:  opnd_sel = {1'b0, y_reg[CHUNK_W-1:0]};
            SEL_Y1:  opnd_sel = {1'b0, y_reg[2*CHUNK_W-1:CHUNK_W]};
            SEL_Y2:  opnd_sel = {1'b0, y_reg[ACC_W-1:2*CHUNK_W]};
            default: opnd_sel = '0;
        endcase
        coef_sel = (op.sel == SEL_X0 || op.sel == SEL_X1) ? coef_b(op.phase)
                                                          : coef_a(op.phase);
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= coef_sel * opnd_sel;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            op_reg <= '0;
        else
            op_reg <= op;
    end

    always_comb
    begin
        term_ext = {{(ACC_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
        neg      = 1'b1;
        unique case (op_reg.sel)
            SEL_X0:  begin term = term_ext;                neg = 1'b0; end
            SEL_X1:  begin term = term_ext << CHUNK_W;     neg = 1'b0; end
            SEL_Y0:  term = term_ext;
            SEL_Y1:  term = term_ext << CHUNK_W;
            SEL_Y2:  term = term_ext << (2 * CHUNK_W);
            default: begin term = '0;                      neg = 1'b0; end
        endcase

        rd_full = (op_reg.phase == '0) ? (NDLY - 1'b1) : (NDLY - 1'b1 - op_reg.phase);
        wr_full = NDLY - op_reg.phase;
        if (op_reg.phase == '0 || op_reg.phase < NDLY)
            init = dly_reg[rd_full[DIDX_W-1:0]];
        else
            init = '0;

        base     = op_reg.first ? init : acc_reg;
        acc_next = base + (neg ? ~term : term) + {{(ACC_W-1){1'b0}}, neg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
            y_reg   <= '0;
            for (int i = 0; i < NDELAY; i++)
                dly_reg[i] <= '0;
        end
        else if (op_reg.valid)
        begin
            acc_reg <= acc_next;
            if (op_reg.last)
            begin
                if (op_reg.phase == '0)
                    y_reg <= acc_next;
                else
                    dly_reg[wr_full[DIDX_W-1:0]] <= acc_next;
            end
        end
    end

    assign y = y_reg;

endmodule

### design/iir_df2t_order6_filter_core.sv
// Top level of the order-6 transposed direct form II IIR filter.
// A new sample is stalled until the previous result is loaded; one multiplier is shared by all operations.
// A finished result waits in the output register while the next sample is taken.
// Reset clears the delay line, the sequencer and the result valid flag.
module iir_df2t_order6_filter_core
    import iirdf_pkg::*;
#(
    parameter int TAPS = TAPS_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       sample_valid,
    output logic                       sample_stall,
    input  logic signed [SAMPLE_W-1:0] sample,
    input  logic [KEEP_W-1:0]          byte_keep,
    input  logic [KEEP_W-1:0]          byte_strobe,
    input  logic                       side_user,
    input  logic                       side_id,
    input  logic                       side_dest,
    input  logic                       end_of_packet,
    output logic                       filtered_valid,
    input  logic                       filtered_stall,
    output logic signed [SAMPLE_W-1:0] filtered,
    output logic [KEEP_W-1:0]          out_keep,
    output logic [KEEP_W-1:0]          out_strobe,
    output logic                       out_user,
    output logic                       out_id,
    output logic                       out_dest,
    output logic                       out_last
);

    logic                start;
    logic                busy;
    logic                load_out;
    logic                slot_free;
    mac_op_t             op;
    logic [ACC_W-1:0]    y;
    logic [SAMPLE_W-1:0] x_reg;
    logic [KEEP_W-1:0]   keep_reg, strobe_reg;
    logic                user_reg, id_reg, dest_reg, last_reg;
    logic                out_valid_reg;

    assign sample_stall = busy;
    assign start        = sample_valid && !busy;
    assign slot_free    = !out_valid_reg || !filtered_stall;

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg      <= sample;
            keep_reg   <= byte_keep;
            strobe_reg <= byte_strobe;
            user_reg   <= side_user;
            id_reg     <= side_id;
            dest_reg   <= side_dest;
            last_reg   <= end_of_packet;
        end
    end

    iirdf_seq #(.TAPS(TAPS)) u_seq
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .slot_free (slot_free),
        .op        (op),
        .busy      (busy),
        .load_out  (load_out)
    );

    iirdf_mac #(.TAPS(TAPS)) u_mac
    (
        .clk   (clk),
        .rst_n (rst_n),
        .op    (op),
        .x     (x_reg),
        .y     (y)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (load_out)
            out_valid_reg <= 1'b1;
        else if (!filtered_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            filtered   <= y[SHIFT_OUT+SAMPLE_W-1:SHIFT_OUT];
            out_keep   <= keep_reg;
            out_strobe <= strobe_reg;
            out_user   <= user_reg;
            out_id     <= id_reg;
            out_dest   <= dest_reg;
            out_last   <= last_reg;
        end
    end

    assign filtered_valid = out_valid_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        sample_valid && !sample_stall |=> sample_stall)
    else $error("sample transfer did not start the sequencer");

    assert property (@(posedge clk) disable iff (!rst_n)
        load_out |-> slot_free)
    else $error("result loaded over an unread result");

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(filtered_valid) |-> $past(sample_stall))
    else $error("result appeared without a sample in progress");

    assert property (@(posedge clk) disable iff (!rst_n)
        op.valid |-> busy)
    else $error("operation issued while idle");

endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for the order-6 DF2T IIR filter core: queued stimulus, predictor, scoreboard.
module tb_top;
    import iirdf_pkg::*;

    localparam int NDLY           = TAPS_DEF - 1;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 100;
    localparam int RANDOM_ITEMS   = 1400;
    localparam int CALM_TAIL      = 150;
    localparam int HOLD_AFTER     = 200;
    localparam int HOLD_CYCLES    = 400;
    localparam int REPORT_MAX     = 10;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] x;
        logic [KEEP_W-1:0]          keep;
        logic [KEEP_W-1:0]          strb;
        logic                       user;
        logic                       id;
        logic                       dest;
        logic                       last;
    } beat_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       sample_valid = 1'b0;
    logic                       sample_stall;
    logic signed [SAMPLE_W-1:0] sample = '0;
    logic [KEEP_W-1:0]          byte_keep = '0;
    logic [KEEP_W-1:0]          byte_strobe = '0;
    logic                       side_user = 1'b0;
    logic                       side_id = 1'b0;
    logic                       side_dest = 1'b0;
    logic                       end_of_packet = 1'b0;
    logic                       filtered_valid;
    logic                       filtered_stall = 1'b0;
    logic signed [SAMPLE_W-1:0] filtered;
    logic [KEEP_W-1:0]          out_keep;
    logic [KEEP_W-1:0]          out_strobe;
    logic                       out_user;
    logic                       out_id;
    logic                       out_dest;
    logic                       out_last;

    beat_t                   pending_samples[$];
    beat_t                   predicted_outputs[$];
    logic signed [ACC_W-1:0] delay_s [0:NDLY-1];

    logic in_taken = 1'b0;
    int   gap_left = 0;
    int   stall_left = 0;
    int   hold_left = 0;
    logic hold_done = 1'b0;
    int   results_seen = 0;
    int   mismatches = 0;
    int   idle_cycles = 0;

    iir_df2t_order6_filter_core dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .sample_valid   (sample_valid),
        .sample_stall   (sample_stall),
        .sample         (sample),
        .byte_keep      (byte_keep),
        .byte_strobe    (byte_strobe),
        .side_user      (side_user),
        .side_id        (side_id),
        .side_dest      (side_dest),
        .end_of_packet  (end_of_packet),
        .filtered_valid (filtered_valid),
        .filtered_stall (filtered_stall),
        .filtered       (filtered),
        .out_keep       (out_keep),
        .out_strobe     (out_strobe),
        .out_user       (out_user),
        .out_id         (out_id),
        .out_dest       (out_dest),
        .out_last       (out_last)
    );

    always #10 clk = ~clk;

    function automatic logic signed [ACC_W-1:0] num_coef(input int k);
        logic signed [ACC_W-1:0] c;
        case (k)
            0, 6:    c = 96'sd17;
            1, 5:    c = 96'sd100;
            2, 4:    c = 96'sd249;
            3:       c = 96'sd332;
            default: c = '0;
        endcase
        return c;
    endfunction

    function automatic logic signed [ACC_W-1:0] den_coef(input int k);
        logic signed [ACC_W-1:0] c;
        case (k)
            0:       c = 96'sd33554432;
            1:       c = -96'sd176896233;
            2:       c = 96'sd389900074;
            3:       c = -96'sd459786179;
            4:       c = 96'sd305884427;
            5:       c = -96'sd108831111;
            6:       c = 96'sd16175653;
            default: c = '0;
        endcase
        return c;
    endfunction

    task automatic iir_advance(input logic signed [SAMPLE_W-1:0] x,
                               output logic signed [SAMPLE_W-1:0] res);
        logic signed [ACC_W-1:0] xw;
        logic signed [ACC_W-1:0] y;
        xw = x;
        y = num_coef(0) * xw + delay_s[NDLY-1];
        for (int k = NDLY - 1; k > 0; k--)
            delay_s[k] = delay_s[k-1] + num_coef(TAPS_DEF - 1 - k) * xw
                         - den_coef(TAPS_DEF - 1 - k) * y;
        delay_s[0] = num_coef(TAPS_DEF - 1) * xw - den_coef(TAPS_DEF - 1) * y;
        res = y[SHIFT_OUT +: SAMPLE_W];
    endtask

    task automatic queue_sample(input logic [SAMPLE_W-1:0] x, input logic [KEEP_W-1:0] keep,
                                input logic [KEEP_W-1:0] strb, input logic user,
                                input logic id, input logic dest, input logic last);
        beat_t b;
        b.x    = x;
        b.keep = keep;
        b.strb = strb;
        b.user = user;
        b.id   = id;
        b.dest = dest;
        b.last = last;
        pending_samples.push_back(b);
    endtask

    always @(negedge clk)
    begin : driver
        beat_t nxt;
        if (rst_n && (in_taken || !sample_valid))
        begin
            if (gap_left > 0)
            begin
                sample_valid <= 1'b0;
                gap_left     <= gap_left - 1;
            end
            else if (pending_samples.size() > 0)
            begin
                nxt = pending_samples.pop_front();
                sample        <= nxt.x;
                byte_keep     <= nxt.keep;
                byte_strobe   <= nxt.strb;
                side_user     <= nxt.user;
                side_id       <= nxt.id;
                side_dest     <= nxt.dest;
                end_of_packet <= nxt.last;
                sample_valid  <= 1'b1;
                if (pending_samples.size() > CALM_TAIL && $urandom_range(0, 3) == 0)
                    gap_left <= $urandom_range(1, 8);
            end
            else
            begin
                sample_valid <= 1'b0;
            end
        end
    end

    always @(negedge clk)
    begin : receiver
        if (hold_left > 0)
        begin
            filtered_stall <= 1'b1;
            hold_left      <= hold_left - 1;
        end
        else if (!hold_done && results_seen >= HOLD_AFTER)
        begin
            filtered_stall <= 1'b1;
            hold_left      <= HOLD_CYCLES - 1;
            hold_done      <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            filtered_stall <= 1'b1;
            stall_left     <= stall_left - 1;
        end
        else if (pending_samples.size() > CALM_TAIL && $urandom_range(0, 4) == 0)
        begin
            filtered_stall <= 1'b1;
            stall_left     <= $urandom_range(0, 7);
        end
        else
        begin
            filtered_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin : monitor
        beat_t                      got;
        beat_t                      want;
        logic signed [SAMPLE_W-1:0] y_out;
        logic                       in_xfer;
        logic                       out_xfer;
        in_xfer  = rst_n && sample_valid && !sample_stall;
        out_xfer = rst_n && filtered_valid && !filtered_stall;
        in_taken <= in_xfer;
        if (in_xfer)
        begin
            iir_advance(sample, y_out);
            want.x    = y_out;
            want.keep = byte_keep;
            want.strb = byte_strobe;
            want.user = side_user;
            want.id   = side_id;
            want.dest = side_dest;
            want.last = end_of_packet;
            predicted_outputs.push_back(want);
        end
        if (out_xfer)
        begin
            got.x    = filtered;
            got.keep = out_keep;
            got.strb = out_strobe;
            got.user = out_user;
            got.id   = out_id;
            got.dest = out_dest;
            got.last = out_last;
            results_seen = results_seen + 1;
            if (predicted_outputs.size() == 0)
            begin
                mismatches = mismatches + 1;
                if (mismatches <= REPORT_MAX)
                    $display("unexpected result #%0d: filtered=%0d keep=%h strb=%h u=%b i=%b d=%b l=%b",
                             results_seen, got.x, got.keep, got.strb, got.user, got.id,
                             got.dest, got.last);
            end
            else
            begin
                want = predicted_outputs.pop_front();
                if (got.x !== want.x || got.keep !== want.keep || got.strb !== want.strb ||
                    got.user !== want.user || got.id !== want.id ||
                    got.dest !== want.dest || got.last !== want.last)
                begin
                    mismatches = mismatches + 1;
                    if (mismatches <= REPORT_MAX)
                    begin
                        $display("result #%0d expected filtered=%0d keep=%h strb=%h u=%b i=%b d=%b l=%b",
                                 results_seen, want.x, want.keep, want.strb, want.user,
                                 want.id, want.dest, want.last);
                        $display("result #%0d actual   filtered=%0d keep=%h strb=%h u=%b i=%b d=%b l=%b",
                                 results_seen, got.x, got.keep, got.strb, got.user,
                                 got.id, got.dest, got.last);
                    end
                end
            end
        end
        if (in_xfer || out_xfer)
            idle_cycles = 0;
        else if (rst_n)
            idle_cycles = idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("iir_df2t_order6_filter_core: mismatch");
            $finish;
        end
    end

    initial
    begin : stimulus
        logic [SAMPLE_W-1:0] raw;
        logic [SAMPLE_W-1:0] val;
        int                  kind;
        int                  pkt_left;
        for (int k = 0; k < NDLY; k++)
            delay_s[k] = '0;

        queue_sample(64'd0, 8'hFF, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0);
        queue_sample(64'd1, 8'h00, 8'hFF, 1'b1, 1'b1, 1'b1, 1'b0);
        for (int k = 0; k < 6; k++)
            queue_sample(64'd0, 8'hA5, 8'h5A, k[0], k[1], k[2], k == 5);
        queue_sample(64'h7FFF_FFFF_FFFF_FFFF, 8'hFF, 8'hFF, 1'b1, 1'b0, 1'b1, 1'b0);
        queue_sample(64'h7FFF_FFFF_FFFF_FFFF, 8'h00, 8'h00, 1'b0, 1'b1, 1'b0, 1'b0);
        queue_sample(64'h8000_0000_0000_0000, 8'h0F, 8'hF0, 1'b1, 1'b1, 1'b0, 1'b0);
        queue_sample(64'h8000_0000_0000_0000, 8'hF0, 8'h0F, 1'b0, 1'b0, 1'b1, 1'b1);
        queue_sample(64'hFFFF_FFFF_FFFF_FFFF, 8'h01, 8'h80, 1'b1, 1'b0, 1'b0, 1'b0);
        queue_sample(64'h5555_5555_5555_5555, 8'h55, 8'hAA, 1'b0, 1'b1, 1'b1, 1'b0);
        queue_sample(64'hAAAA_AAAA_AAAA_AAAA, 8'hAA, 8'h55, 1'b1, 1'b1, 1'b1, 1'b1);
        for (int k = 0; k < 4; k++)
            queue_sample(64'h7FFF_FFFF_FFFF_FFFF, 8'hFF, 8'hFF, 1'b0, 1'b0, 1'b0, 1'b0);
        for (int k = 0; k < 4; k++)
            queue_sample(64'h8000_0000_0000_0000, 8'h00, 8'h00, 1'b1, 1'b1, 1'b1, k == 3);

        pkt_left = $urandom_range(1, 16);
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            raw  = {$urandom, $urandom};
            kind = $urandom_range(0, 9);
            if (kind <= 5)
                val = $signed(raw) >>> $urandom_range(20, 62);
            else if (kind == 6)
                val = raw;
            else if (kind == 7)
                val = 64'h7FFF_FFFF_FFFF_FFFF;
            else if (kind == 8)
                val = 64'h8000_0000_0000_0000;
            else
                val = '0;
            pkt_left = pkt_left - 1;
            queue_sample(val, KEEP_W'($urandom_range(0, 255)), KEEP_W'($urandom_range(0, 255)),
                         1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                         1'($urandom_range(0, 1)), pkt_left == 0);
            if (pkt_left == 0)
                pkt_left = $urandom_range(1, 16);
        end

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (pending_samples.size() != 0 || sample_valid || predicted_outputs.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && predicted_outputs.size() == 0)
            $display("iir_df2t_order6_filter_core: match");
        else
            $display("iir_df2t_order6_filter_core: mismatch");
        $finish;
    end

endmodule

### files.f
design/iirdf_pkg.sv
design/iirdf_seq.sv
design/iirdf_mac.sv
design/iir_df2t_order6_filter_core.sv
bench/tb_top.sv
